// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the stable priority queue
// Operation and status codes, default sizes and the cell control struct.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default sizes
  localparam int SPQ_DEPTH         = 16;
  localparam int SPQ_PAYLOAD_BITS  = 32;
  localparam int SPQ_PRIORITY_BITS = 8;

  // Operation carried by an input beat
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_t;

  // Status carried by a result beat
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

// ===== rtl/spq_in_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if: request channel
// Valid/ready channel carrying one queue operation per beat.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS  = SPQ_PAYLOAD_BITS,
  parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
);
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [PAYLOAD_BITS-1:0]         payload;
  logic signed [PRIORITY_BITS-1:0] priority_req;

  modport source (output valid, opcode, payload, priority_req, input ready);
  modport sink   (input valid, opcode, payload, priority_req, output ready);
endinterface

// ===== rtl/spq_out_if.sv =====
// ----------------------------------------------------------------------------
// spq_out_if: result channel
// Valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface spq_out_if
  import spq_pkg::*;
#(
  parameter int DEPTH        = SPQ_DEPTH,
  parameter int PAYLOAD_BITS = SPQ_PAYLOAD_BITS
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [PAYLOAD_BITS-1:0] item_out;
  logic [CNT_W-1:0]        occupancy;

  modport source (output valid, status, item_out, occupancy, input ready);
  modport sink   (input valid, status, item_out, occupancy, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds one entry; on enqueue it holds, takes the new entry or takes its left
// neighbour, on dequeue it takes its right neighbour.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS  = SPQ_PAYLOAD_BITS,
  parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
) (
  input  logic                            clk,
  input  spq_ctl_t                        ctl,
  input  logic                            occupied,
  input  logic [PAYLOAD_BITS-1:0]         new_payload,
  input  logic signed [PRIORITY_BITS-1:0] new_prio,
  input  logic                            left_keep,
  input  logic [PAYLOAD_BITS-1:0]         left_payload,
  input  logic signed [PRIORITY_BITS-1:0] left_prio,
  input  logic [PAYLOAD_BITS-1:0]         right_payload,
  input  logic signed [PRIORITY_BITS-1:0] right_prio,
  output logic                            keep,
  output logic [PAYLOAD_BITS-1:0]         payload,
  output logic signed [PRIORITY_BITS-1:0] prio
);

  logic [PAYLOAD_BITS-1:0]         payload_r, payload_nxt;
  logic signed [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // Stay put when the entry here ranks at or above the new one
  assign keep = occupied && (prio_r >= new_prio);

  // Select the next content of the slot
  always_comb begin
    payload_nxt = payload_r;
    prio_nxt    = prio_r;
    if (ctl.enq && !keep) begin
      if (left_keep) begin
        payload_nxt = new_payload;
        prio_nxt    = new_prio;
      end else begin
        payload_nxt = left_payload;
        prio_nxt    = left_prio;
      end
    end else if (ctl.deq) begin
      payload_nxt = right_payload;
      prio_nxt    = right_prio;
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
    prio_r    <= prio_nxt;
  end

  assign payload = payload_r;
  assign prio    = prio_r;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// The result of an accepted request beat is registered and offered in the cycle after.
// Throughput: one enqueue or dequeue per cycle; every cell compares and shifts
// in parallel, and the output register frees whenever the result side takes.
// Reset clears the entry count and the output valid flag; cell contents are not
// cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted shift-register priority queue
// Highest priority at the head, first-in-first-out among equal priorities.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH         = SPQ_DEPTH,
  parameter int PAYLOAD_BITS  = SPQ_PAYLOAD_BITS,
  parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic [1:0]              status_r, status_nxt;
  logic [PAYLOAD_BITS-1:0] item_r, item_nxt;
  logic [CNT_W-1:0]        occ_r;

  logic     fire, full, empty, is_deq;
  spq_ctl_t ctl;

  logic [PAYLOAD_BITS-1:0]         pay_w  [DEPTH];
  logic signed [PRIORITY_BITS-1:0] prio_w [DEPTH];
  logic                            keep_w [DEPTH];

  // Accept while the output register is free or being emptied
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);
  assign is_deq      = (spq_op_t'(in_ch.opcode) == OP_DEQ);
  assign ctl.enq     = fire && !is_deq && !full;
  assign ctl.deq     = fire && is_deq && !empty;

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                            lkeep;
    logic [PAYLOAD_BITS-1:0]         lpay, rpay;
    logic signed [PRIORITY_BITS-1:0] lprio, rprio;

    if (i == 0) begin : g_head
      assign lkeep = 1'b1;
      assign lpay  = in_ch.payload;
      assign lprio = in_ch.priority_req;
    end else begin : g_body
      assign lkeep = keep_w[i-1];
      assign lpay  = pay_w[i-1];
      assign lprio = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rpay  = pay_w[i];
      assign rprio = prio_w[i];
    end else begin : g_inner
      assign rpay  = pay_w[i+1];
      assign rprio = prio_w[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occupied      (CNT_W'(i) < count_r),
      .new_payload   (in_ch.payload),
      .new_prio      (in_ch.priority_req),
      .left_keep     (lkeep),
      .left_payload  (lpay),
      .left_prio     (lprio),
      .right_payload (rpay),
      .right_prio    (rprio),
      .keep          (keep_w[i]),
      .payload       (pay_w[i]),
      .prio          (prio_w[i])
    );
  end

  // Work out count, status and item for the accepted beat
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    item_nxt   = '0;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
      item_nxt  = pay_w[0];
    end else if (is_deq) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_FULL;
    end
  end

  // Hold count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      status_r <= status_nxt;
      item_r   <= item_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.item_out  = item_r;
  assign out_ch.occupancy = occ_r;

  // Count never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // A pending result reports the current count
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> occ_r == count_r)
    else $error("occupancy differs from entry count");

  // A full refusal only happens with every cell occupied
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> full)
    else $error("full status with free cells");

  // Only a completed operation returns a nonzero item
  a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && item_r != '0) |-> status_r == ST_DONE)
    else $error("item returned with error status");

  // The two leading entries stay in priority order
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> prio_w[0] >= prio_w[1])
    else $error("head entries out of order");

endmodule

// ===== sim/stable_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the sorted priority queue
// Drives enqueue and dequeue beats through the request channel, keeps its own
// sorted copy of the queue contents to predict each result beat, and checks
// status, removed payload and occupancy in order. Both channels stall at
// random, and the queue is driven through empty, full and tied priorities.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH         = SPQ_DEPTH;
  localparam int PAYLOAD_BITS  = SPQ_PAYLOAD_BITS;
  localparam int PRIORITY_BITS = SPQ_PRIORITY_BITS;
  localparam int ITEMS_PER_PHASE = 550;
  localparam int QUIET_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 40;

  typedef struct {
    spq_op_t                         op;
    logic [PAYLOAD_BITS-1:0]         payload;
    logic signed [PRIORITY_BITS-1:0] prio;
  } spq_request_t;

  typedef struct {
    spq_status_t             status;
    logic [PAYLOAD_BITS-1:0] item;
    int                      occupancy;
  } spq_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  #(.PAYLOAD_BITS(PAYLOAD_BITS), .PRIORITY_BITS(PRIORITY_BITS)) in_ch ();
  spq_out_if #(.DEPTH(DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) out_ch ();

  stable_priority_queue #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predicted queue contents, head at index 0
  logic [PAYLOAD_BITS-1:0]         sorted_payload [DEPTH];
  logic signed [PRIORITY_BITS-1:0] sorted_prio    [DEPTH];
  int                              held_count;

  spq_request_t pending_requests[$];
  spq_result_t  awaited_results[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  phase_items;
  int  fail_count;
  int  quiet_cycles;
  bit  in_beat;
  int  n_enq_ok, n_enq_full, n_deq_ok, n_deq_empty, n_results;

  always #6 clk = ~clk;

  // Apply one operation to the predicted contents and return its result
  function automatic spq_result_t apply_operation(input spq_request_t req);
    spq_result_t                     res;
    int                              pos;
    logic signed [PRIORITY_BITS-1:0] new_prio;
    res.status = ST_DONE;
    res.item   = '0;
    new_prio   = req.prio;
    if (req.op == OP_ENQ) begin
      if (held_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // insert behind every entry of equal or higher priority
        pos = 0;
        while (pos < held_count && $signed(sorted_prio[pos]) >= $signed(new_prio))
          pos++;
        for (int i = held_count; i > pos; i--) begin
          sorted_payload[i] = sorted_payload[i-1];
          sorted_prio[i]    = sorted_prio[i-1];
        end
        sorted_payload[pos] = req.payload;
        sorted_prio[pos]    = new_prio;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.item = sorted_payload[0];
        for (int i = 1; i < held_count; i++) begin
          sorted_payload[i-1] = sorted_payload[i];
          sorted_prio[i-1]    = sorted_prio[i];
        end
        held_count--;
      end
    end
    res.occupancy = held_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic push_request(input spq_op_t op, input logic [PAYLOAD_BITS-1:0] pay,
                              input logic signed [PRIORITY_BITS-1:0] pr);
    spq_request_t req;
    req.op      = op;
    req.payload = pay;
    req.prio    = pr;
    pending_requests.push_back(req);
    phase_items++;
  endtask

  // Priorities lean on a narrow band so that ties are common
  function automatic logic signed [PRIORITY_BITS-1:0] pick_prio();
    logic signed [PRIORITY_BITS-1:0] pr;
    case ($urandom_range(0, 3))
      0:       pr = PRIORITY_BITS'($urandom_range(0, 255));
      1:       pr = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      default: pr = PRIORITY_BITS'($urandom_range(0, 4) - 2);
    endcase
    return pr;
  endfunction

  function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
    logic [PAYLOAD_BITS-1:0] pay;
    case ($urandom_range(0, 15))
      0:       pay = '0;
      1:       pay = '1;
      default: pay = $urandom;
    endcase
    return pay;
  endfunction

  // One random sequence: a fill burst, a drain burst or a mixed run
  task automatic push_random_sequence();
    int kind;
    int n;
    int enq_pct;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      n = $urandom_range(14, 20);
      repeat (n) push_request(OP_ENQ, pick_payload(), pick_prio());
    end else if (kind < 4) begin
      n = $urandom_range(10, 20);
      repeat (n) push_request(OP_DEQ, pick_payload(), pick_prio());
    end else begin
      n       = $urandom_range(8, 30);
      enq_pct = $urandom_range(20, 80);
      repeat (n) begin
        if ($urandom_range(0, 99) < enq_pct)
          push_request(OP_ENQ, pick_payload(), pick_prio());
        else
          push_request(OP_DEQ, pick_payload(), pick_prio());
      end
    end
  endtask

  // Hold the sender until every awaited result has come back; look just after
  // the falling edge so the driver's update has settled
  task automatic drain_all();
    do begin
      @(negedge clk);
      #1;
    end while (pending_requests.size() != 0 || in_ch.valid || awaited_results.size() != 0);
  endtask

  // Request driver: change inputs on the falling edge
  always @(negedge clk) begin : request_driver
    spq_request_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= req.op;
        in_ch.payload      <= req.payload;
        in_ch.priority_req <= req.prio;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: check result beats, predict on request beats, watch for stalls
  always @(posedge clk) begin : beat_monitor
    spq_result_t  want;
    spq_request_t req;
    bit           out_beat;
    out_beat = rst_n && out_ch.valid && out_ch.ready;
    in_beat  = rst_n && in_ch.valid && in_ch.ready;

    if (out_beat) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_ch.status, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.item_out !== want.item)
          report_mismatch("item_out", out_ch.item_out, want.item);
        if (out_ch.occupancy !== want.occupancy[4:0])
          report_mismatch("occupancy", out_ch.occupancy, want.occupancy);
      end
    end

    if (in_beat) begin
      req.op      = spq_op_t'(in_ch.opcode);
      req.payload = in_ch.payload;
      req.prio    = in_ch.priority_req;
      want = apply_operation(req);
      awaited_results.push_back(want);
      case (want.status)
        ST_FULL:  n_enq_full++;
        ST_EMPTY: n_deq_empty++;
        default: begin
          if (req.op == OP_ENQ) n_enq_ok++;
          else n_deq_ok++;
        end
      endcase
    end

    // advance the stall watchdog
    if (!rst_n || in_beat || out_beat) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and run control
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_ENQ;
    in_ch.payload      = '0;
    in_ch.priority_req = '0;
    out_ch.ready       = 1'b0;
    held_count   = 0;
    fail_count   = 0;
    quiet_cycles = 0;
    in_beat      = 1'b0;
    n_enq_ok = 0; n_enq_full = 0; n_deq_ok = 0; n_deq_empty = 0; n_results = 0;
    send_idle_pct = 11;
    recv_idle_pct = 52;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      phase_items = 0;
      case (phase)
        0: begin send_idle_pct = 11; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        // empty dequeue, extreme fields, ties kept in arrival order
        push_request(OP_DEQ, '1, 8'sd127);
        push_request(OP_ENQ, '1, 8'sd127);
        push_request(OP_ENQ, '0, -8'sd128);
        push_request(OP_ENQ, 32'h0000_0001, 8'sd0);
        push_request(OP_ENQ, 32'h0000_0002, 8'sd0);
        push_request(OP_ENQ, 32'h0000_0003, 8'sd0);
        push_request(OP_ENQ, 32'h8000_0000, -8'sd1);
        push_request(OP_ENQ, 32'h5555_5555, -8'sd128);
        push_request(OP_ENQ, 32'hAAAA_AAAA, 8'sd1);
        repeat (8) push_request(OP_DEQ, '0, '0);
        push_request(OP_DEQ, 32'h1234_5678, -8'sd128);
      end

      while (phase_items < ITEMS_PER_PHASE) push_random_sequence();
      drain_all();
    end

    // allow time for any outstanding result beat
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", awaited_results.size(), 0);

    $display("Run covered %0d requests: %0d enqueues, %0d refused while full,",
             n_enq_ok + n_enq_full + n_deq_ok + n_deq_empty, n_enq_ok, n_enq_full);
    $display("  %0d dequeues, %0d on an empty queue; %0d result beats checked.",
             n_deq_ok, n_deq_empty, n_results);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
